// ===== sv/chp_pkg.sv =====
// Package for the coin hopper payout controller.
// Holds event codes, register indexes, phase codes and controller command types.
package chp_pkg;

    localparam int MaxHoppers   = 4;
    localparam int DefSpinTime  = 100000;
    localparam int DefKickTime  = 50000;
    localparam int CfgIdxW      = 3;
    localparam int CfgDataW     = 64;

    localparam logic [2:0] EV_RESET = 3'd0;
    localparam logic [2:0] EV_MOTOR = 3'd1;
    localparam logic [2:0] EV_OPTO_WR = 3'd2;
    localparam logic [2:0] EV_OPTO_RD = 3'd3;
    localparam logic [2:0] EV_TICK = 3'd4;
    localparam logic [2:0] EV_COIN = 3'd5;
    localparam logic [2:0] EV_LOAD = 3'd6;

    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_COINSEL = 3'd1;
    localparam logic [2:0] REG_FULL = 3'd2;
    localparam logic [2:0] REG_LOW = 3'd3;
    localparam logic [2:0] REG_HIGH = 3'd4;
    localparam logic [2:0] REG_LOWCHK = 3'd5;
    localparam logic [2:0] REG_HIGHCHK = 3'd6;
    localparam logic [2:0] REG_INMODE = 3'd7;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SPIN = 2'd1;
    localparam logic [1:0] PH_KICK = 2'd2;

    localparam logic [7:0] CODE_COIN0 = 8'h29;
    localparam logic [7:0] CODE_COIN_LO = 8'h30;
    localparam logic [7:0] CODE_COIN_HI = 8'h3F;
    localparam logic [7:0] CODE_REFILL_LO = 8'h50;
    localparam logic [7:0] CODE_REFILL_HI = 8'h5F;
    localparam logic [7:0] PLAIN_LIMIT = 8'd13;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the input word
        logic exec;      // apply the event to the addressed hopper
        logic scan;      // examine one hopper for coin routing
        logic commit;    // apply the coin to the chosen hopper
        logic publish;   // load the output register
    } chp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_coin;
        logic scan_last;
    } chp_sts_t;

endpackage

// ===== sv/chp_ctrl.sv =====
// Controller state machine of the coin hopper payout controller.
// Depends on chp_pkg for the command and status types.
module chp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  chp_pkg::chp_sts_t sts,
    output chp_pkg::chp_cmd_t cmd
);
    import chp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SCAN = 5'b00100,
        S_COMMIT = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign out_valid = out_valid_reg;
    // accept a new word only while idle; a stalled result waits in S_DONE
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.is_coin)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.exec = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/chp_datapath.sv =====
// Datapath of the coin hopper payout controller: configuration, hopper state,
// event execution, routing scan and output word. Depends on chp_pkg.
module chp_datapath
#(
    parameter int NUM_HOPPERS = chp_pkg::MaxHoppers,
    parameter int SPIN_TIME = chp_pkg::DefSpinTime,
    parameter int KICK_TIME = chp_pkg::DefKickTime
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [chp_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [chp_pkg::CfgDataW-1:0]  cfg_data,
    input  chp_pkg::chp_cmd_t             cmd,
    output chp_pkg::chp_sts_t             sts,
    input  logic [2:0]                    mode,
    input  logic [3:0]                    hopper,
    input  logic                          flag_in,
    input  logic [15:0]                   tick_cycles,
    input  logic [7:0]                    coin_code,
    input  logic [15:0]                   level_value,
    output logic                          opto_out,
    output logic                          coin_routed,
    output logic [3:0]                    coin_hopper,
    output logic [15:0]                   hopper_level_out,
    output logic [31:0]                   coins_in_out,
    output logic [31:0]                   coins_paid_out,
    output logic [31:0]                   coins_refilled_out,
    output logic                          low_flag,
    output logic                          high_flag,
    output logic [1:0]                    motor_phase
);
    import chp_pkg::*;

    localparam int N = NUM_HOPPERS;
    localparam logic [31:0] SpinT = 32'(SPIN_TIME);
    localparam logic [31:0] KickT = 32'(KICK_TIME);

    // configuration
    logic [3:0]  en_mask_reg, lchk_reg, hchk_reg;
    logic [19:0] coinsel_reg;
    logic [63:0] full_reg, lowlv_reg, highlv_reg;
    logic        inmode_reg;

    // hopper state
    logic [N-1:0] motor_on_reg, motor_prev_reg, opto_en_reg, opto_flag_reg;
    logic [N-1:0] low_ind_reg, high_ind_reg;
    logic [1:0]   phase_reg [N];
    logic [31:0]  timer_reg [N];
    logic [15:0]  level_reg [N];
    logic [31:0]  cin_reg [N];
    logic [31:0]  cpaid_reg [N];
    logic [31:0]  crefill_reg [N];

    // captured word
    logic [2:0]  mode_reg;
    logic [3:0]  hop_reg;
    logic        flag_reg;
    logic [15:0] cyc_reg;
    logic [7:0]  code_reg;
    logic [15:0] lvl_reg;

    // scan state
    logic [1:0]  idx_reg;
    logic        found_reg, found_next;
    logic [1:0]  pick_reg, pick_next;
    logic        routed_reg;
    logic [1:0]  routed_h_reg;

    // decode of the coin code
    logic        code_ok, refill;
    logic [4:0]  want;

    always_comb
    begin
        code_ok = 1'b0;
        refill = 1'b0;
        want = '0;
        if (!inmode_reg)
        begin
            code_ok = (code_reg < PLAIN_LIMIT);
            want = code_reg[4:0];
        end
        else if (code_reg == CODE_COIN0)
        begin
            code_ok = 1'b1;
        end
        else if (code_reg >= CODE_COIN_LO && code_reg <= CODE_COIN_HI)
        begin
            code_ok = 1'b1;
            want = 5'(code_reg - CODE_COIN_LO) + 5'd1;
        end
        else if (code_reg >= CODE_REFILL_LO && code_reg <= CODE_REFILL_HI)
        begin
            code_ok = 1'b1;
            refill = 1'b1;
            want = 5'(code_reg - CODE_REFILL_LO) + 5'd1;
        end
    end

    logic       hvalid;
    logic [1:0] h;
    assign hvalid = (32'(hop_reg) < 32'(N));
    assign h = hop_reg[1:0];

    logic [1:0] si;
    logic       s_match, s_notfull;
    assign si = idx_reg;
    assign s_match = en_mask_reg[si] && (coinsel_reg[5*si +: 5] == want);
    assign s_notfull = level_reg[si] < full_reg[16*si +: 16];

    assign sts.is_coin = (mode_reg == EV_COIN);
    assign sts.scan_last = (32'(idx_reg) == 32'(N - 1));

    always_comb
    begin
        found_next = found_reg;
        pick_next = pick_reg;
        if (code_ok && s_match)
        begin
            if (!inmode_reg)
            begin
                // lowest matching hopper that has room
                if (!found_reg && s_notfull)
                begin
                    found_next = 1'b1;
                    pick_next = si;
                end
            end
            else
            begin
                // last matching hopper, room checked at commit
                found_next = 1'b1;
                pick_next = si;
            end
        end
    end

    // tick arithmetic for the addressed hopper
    logic [31:0] t_load, t_left;
    logic        t_out;
    always_comb
    begin
        t_load = timer_reg[h];
        if (t_load == 32'd0)
        begin
            t_load = (phase_reg[h] == PH_SPIN) ? SpinT : KickT;
        end
        t_out = ({16'd0, cyc_reg} >= t_load);
        t_left = t_out ? 32'd0 : t_load - {16'd0, cyc_reg};
    end

    logic [15:0] pick_lvl_inc;
    assign pick_lvl_inc = level_reg[pick_reg] + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_mask_reg <= '0;
            coinsel_reg <= '0;
            full_reg <= '0;
            lowlv_reg <= '0;
            highlv_reg <= '0;
            lchk_reg <= '0;
            hchk_reg <= '0;
            inmode_reg <= 1'b0;
            motor_on_reg <= '0;
            motor_prev_reg <= '0;
            opto_en_reg <= '0;
            opto_flag_reg <= '0;
            low_ind_reg <= '0;
            high_ind_reg <= '0;
            for (int i = 0; i < N; i++)
            begin
                phase_reg[i] <= PH_IDLE;
                timer_reg[i] <= '0;
                level_reg[i] <= '0;
                cin_reg[i] <= '0;
                cpaid_reg[i] <= '0;
                crefill_reg[i] <= '0;
            end
            idx_reg <= '0;
            found_reg <= 1'b0;
            pick_reg <= '0;
            routed_reg <= 1'b0;
            routed_h_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ENABLE: en_mask_reg <= cfg_data[3:0];
                    REG_COINSEL: coinsel_reg <= cfg_data[19:0];
                    REG_FULL: full_reg <= cfg_data;
                    REG_LOW: lowlv_reg <= cfg_data;
                    REG_HIGH: highlv_reg <= cfg_data;
                    REG_LOWCHK: lchk_reg <= cfg_data[3:0];
                    REG_HIGHCHK: hchk_reg <= cfg_data[3:0];
                    REG_INMODE: inmode_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.capture)
            begin
                idx_reg <= '0;
                found_reg <= 1'b0;
                pick_reg <= '0;
                routed_reg <= 1'b0;
                routed_h_reg <= '0;
            end
            if (cmd.scan)
            begin
                found_reg <= found_next;
                pick_reg <= pick_next;
                if (!sts.scan_last)
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            if (cmd.commit && found_reg &&
                (!inmode_reg || level_reg[pick_reg] < full_reg[16*pick_reg +: 16]))
            begin
                routed_reg <= 1'b1;
                routed_h_reg <= pick_reg;
                level_reg[pick_reg] <= pick_lvl_inc;
                if (refill)
                begin
                    crefill_reg[pick_reg] <= crefill_reg[pick_reg] + 32'd1;
                end
                else
                begin
                    cin_reg[pick_reg] <= cin_reg[pick_reg] + 32'd1;
                end
                if (inmode_reg && lchk_reg[pick_reg])
                begin
                    low_ind_reg[pick_reg] <= pick_lvl_inc < lowlv_reg[16*pick_reg +: 16];
                end
            end
            if (cmd.exec && hvalid)
            begin
                case (mode_reg)
                    EV_RESET:
                    begin
                        motor_on_reg[h] <= 1'b0;
                        motor_prev_reg[h] <= 1'b0;
                        opto_en_reg[h] <= 1'b0;
                        opto_flag_reg[h] <= 1'b0;
                        timer_reg[h] <= '0;
                        phase_reg[h] <= PH_IDLE;
                    end
                    EV_MOTOR:
                    begin
                        if (en_mask_reg[h])
                        begin
                            motor_on_reg[h] <= flag_reg;
                            motor_prev_reg[h] <= flag_reg;
                            if (flag_reg && !motor_prev_reg[h])
                            begin
                                phase_reg[h] <= PH_SPIN;
                                timer_reg[h] <= '0;
                            end
                            else if (!flag_reg && motor_prev_reg[h])
                            begin
                                phase_reg[h] <= PH_IDLE;
                                timer_reg[h] <= '0;
                                opto_flag_reg[h] <= 1'b0;
                            end
                        end
                    end
                    EV_OPTO_WR:
                    begin
                        if (en_mask_reg[h])
                        begin
                            opto_en_reg[h] <= flag_reg;
                        end
                    end
                    EV_TICK:
                    begin
                        if (en_mask_reg[h])
                        begin
                            logic [15:0] nl;
                            nl = level_reg[h];
                            if (motor_on_reg[h] && phase_reg[h] == PH_SPIN)
                            begin
                                timer_reg[h] <= t_left;
                                if (t_out)
                                begin
                                    if (level_reg[h] == 16'd0)
                                    begin
                                        phase_reg[h] <= PH_IDLE;
                                        opto_flag_reg[h] <= 1'b0;
                                    end
                                    else
                                    begin
                                        phase_reg[h] <= PH_KICK;
                                    end
                                end
                                else
                                begin
                                    opto_flag_reg[h] <= 1'b0;
                                end
                            end
                            else if (motor_on_reg[h] && phase_reg[h] == PH_KICK)
                            begin
                                if (timer_reg[h] == 32'd0)
                                begin
                                    cpaid_reg[h] <= cpaid_reg[h] + 32'd1;
                                    if (level_reg[h] != 16'd0)
                                    begin
                                        nl = level_reg[h] - 16'd1;
                                    end
                                end
                                level_reg[h] <= nl;
                                timer_reg[h] <= t_left;
                                if (t_out)
                                begin
                                    phase_reg[h] <= PH_SPIN;
                                    opto_flag_reg[h] <= 1'b0;
                                end
                                else
                                begin
                                    opto_flag_reg[h] <= 1'b1;
                                end
                            end
                            else
                            begin
                                timer_reg[h] <= '0;
                                opto_flag_reg[h] <= 1'b0;
                                phase_reg[h] <= PH_IDLE;
                            end
                            low_ind_reg[h] <= lchk_reg[h] && (nl <= lowlv_reg[16*h +: 16]);
                            high_ind_reg[h] <= hchk_reg[h] && (nl >= highlv_reg[16*h +: 16]);
                        end
                    end
                    EV_LOAD:
                    begin
                        level_reg[h] <= lvl_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    // captured word and output register: payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            hop_reg <= hopper;
            flag_reg <= flag_in;
            cyc_reg <= tick_cycles;
            code_reg <= coin_code;
            lvl_reg <= level_value;
        end
        if (cmd.publish)
        begin
            opto_out <= (mode_reg == EV_OPTO_RD) && hvalid && en_mask_reg[h]
                        && opto_en_reg[h] && opto_flag_reg[h];
            coin_routed <= routed_reg;
            coin_hopper <= {2'b00, routed_h_reg};
            hopper_level_out <= hvalid ? level_reg[h] : '0;
            coins_in_out <= hvalid ? cin_reg[h] : '0;
            coins_paid_out <= hvalid ? cpaid_reg[h] : '0;
            coins_refilled_out <= hvalid ? crefill_reg[h] : '0;
            low_flag <= hvalid && low_ind_reg[h];
            high_flag <= hvalid && high_ind_reg[h];
            motor_phase <= hvalid ? phase_reg[h] : PH_IDLE;
        end
    end

endmodule

// ===== sv/coin_hopper_payout_controller.sv =====
// Top level of the coin hopper payout controller.
// Joins chp_ctrl and chp_datapath; depends on chp_pkg.
//
//  channel   direction  handshake              contents
//  in        to block   in_valid / in_ready    event word (mode, hopper, ...)
//  out       from block out_valid / out_ready  hopper status word
//  cfg       to block   cfg_we                 register index and data
//
// An event word is executed the cycle after accept and its result loaded into
// the output register in S_DONE once that register is free. A coin-in word
// instead runs the routing scan (one hopper per cycle) and a commit step before
// S_DONE. A new word is accepted only in S_IDLE, after the last result is loaded.
// Reset clears configuration, every hopper's state and counters. A stalled
// result holds in the output register; the next result waits in S_DONE.
module coin_hopper_payout_controller
#(
    parameter int NUM_HOPPERS = chp_pkg::MaxHoppers,
    parameter int SPIN_TIME = chp_pkg::DefSpinTime,
    parameter int KICK_TIME = chp_pkg::DefKickTime
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [chp_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [chp_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    mode,
    input  logic [3:0]                    hopper,
    input  logic                          flag_in,
    input  logic [15:0]                   tick_cycles,
    input  logic [7:0]                    coin_code,
    input  logic [15:0]                   level_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          opto_out,
    output logic                          coin_routed,
    output logic [3:0]                    coin_hopper,
    output logic [15:0]                   hopper_level_out,
    output logic [31:0]                   coins_in_out,
    output logic [31:0]                   coins_paid_out,
    output logic [31:0]                   coins_refilled_out,
    output logic                          low_flag,
    output logic                          high_flag,
    output logic [1:0]                    motor_phase
);
    import chp_pkg::*;

    chp_cmd_t cmd;
    chp_sts_t sts;

    // sequence each word: capture, execute or scan and commit, publish
    chp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // hold hopper state and apply each event
    chp_datapath
    #(
        .NUM_HOPPERS (NUM_HOPPERS),
        .SPIN_TIME   (SPIN_TIME),
        .KICK_TIME   (KICK_TIME)
    )
    u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .cmd                (cmd),
        .sts                (sts),
        .mode               (mode),
        .hopper             (hopper),
        .flag_in            (flag_in),
        .tick_cycles        (tick_cycles),
        .coin_code          (coin_code),
        .level_value        (level_value),
        .opto_out           (opto_out),
        .coin_routed        (coin_routed),
        .coin_hopper        (coin_hopper),
        .hopper_level_out   (hopper_level_out),
        .coins_in_out       (coins_in_out),
        .coins_paid_out     (coins_paid_out),
        .coins_refilled_out (coins_refilled_out),
        .low_flag           (low_flag),
        .high_flag          (high_flag),
        .motor_phase        (motor_phase)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for coin_hopper_payout_controller.
// Depends on chp_pkg and the block; a local hopper-bank predictor checks every result word.
module tb;
    import chp_pkg::*;

    localparam int NH = 4;
    localparam int SPIN = 100000;
    localparam int KICK = 50000;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  hopper;
        logic        flag_in;
        logic [15:0] tick_cycles;
        logic [7:0]  coin_code;
        logic [15:0] level_value;
    } event_t;

    typedef struct packed {
        logic        opto;
        logic        routed;
        logic [3:0]  coin_h;
        logic [15:0] level;
        logic [31:0] cin;
        logic [31:0] cpaid;
        logic [31:0] crefill;
        logic        low;
        logic        high;
        logic [1:0]  phase;
    } status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] mode = '0;
    logic [3:0] hopper = '0;
    logic flag_in = 1'b0;
    logic [15:0] tick_cycles = '0;
    logic [7:0] coin_code = '0;
    logic [15:0] level_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic opto_out, coin_routed, low_flag, high_flag;
    logic [3:0] coin_hopper;
    logic [15:0] hopper_level_out;
    logic [31:0] coins_in_out, coins_paid_out, coins_refilled_out;
    logic [1:0] motor_phase;

    coin_hopper_payout_controller uut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor copy of configuration and per-hopper state
    logic [3:0]  p_enable, p_lowchk, p_highchk;
    logic [19:0] p_coinsel;
    logic [63:0] p_full, p_lowlv, p_highlv;
    logic        p_edc;
    logic        m_on[NH], m_prev[NH], o_en[NH], o_flag[NH], ind_low[NH], ind_high[NH];
    logic [1:0]  ph[NH];
    logic [31:0] ph_timer[NH], n_in[NH], n_paid[NH], n_refill[NH];
    logic [15:0] lvl[NH];

    event_t  pending_words[$];
    status_t expected_status[$];
    int      errors = 0;
    int      cycles = 0;
    bit      quiet = 0;       // no idling in the last part of the run
    int      in_gap = 0;
    int      out_gap = 0;

    function automatic logic [15:0] s16(logic [63:0] r, int h);
        return r[16*h +: 16];
    endfunction

    function automatic void clear_bank();
        p_enable = 0; p_lowchk = 0; p_highchk = 0; p_coinsel = 0;
        p_full = 0; p_lowlv = 0; p_highlv = 0; p_edc = 0;
        for (int h = 0; h < NH; h++)
        begin
            m_on[h] = 0; m_prev[h] = 0; o_en[h] = 0; o_flag[h] = 0;
            ind_low[h] = 0; ind_high[h] = 0; ph[h] = PH_IDLE; ph_timer[h] = 0;
            n_in[h] = 0; n_paid[h] = 0; n_refill[h] = 0; lvl[h] = 0;
        end
    endfunction

    // advance one hopper's spin/kick timers by a tick
    function automatic void run_tick(int h, logic [31:0] cyc);
        bit expired;
        if (m_on[h] && ph[h] == PH_SPIN)
        begin
            if (ph_timer[h] == 0) ph_timer[h] = SPIN;
            expired = cyc >= ph_timer[h];
            ph_timer[h] = expired ? 0 : ph_timer[h] - cyc;
            if (expired)
            begin
                if (lvl[h] == 0)
                begin
                    ph[h] = PH_IDLE;
                    o_flag[h] = 0;
                end
                else ph[h] = PH_KICK;
            end
            else o_flag[h] = 0;
        end
        else if (m_on[h] && ph[h] == PH_KICK)
        begin
            if (ph_timer[h] == 0)
            begin
                ph_timer[h] = KICK;
                n_paid[h] += 1;
                if (lvl[h] > 0) lvl[h] -= 1;
            end
            expired = cyc >= ph_timer[h];
            ph_timer[h] = expired ? 0 : ph_timer[h] - cyc;
            if (expired)
            begin
                ph[h] = PH_SPIN;
                o_flag[h] = 0;
            end
            else o_flag[h] = 1;
        end
        else
        begin
            ph_timer[h] = 0; o_flag[h] = 0; ph[h] = PH_IDLE;
        end
        ind_low[h] = p_lowchk[h] && lvl[h] <= s16(p_lowlv, h);
        ind_high[h] = p_highchk[h] && lvl[h] >= s16(p_highlv, h);
    endfunction

    // route one coin code; returns hopper index or -1 for the cashbox
    function automatic int route_coin(logic [7:0] code);
        int pick = -1;
        int want;
        bit refill = 0;
        if (!p_edc)
        begin
            if (code >= PLAIN_LIMIT) return -1;
            for (int h = 0; h < NH; h++)
                if (p_enable[h] && p_coinsel[5*h +: 5] == code && lvl[h] < s16(p_full, h))
                begin
                    lvl[h] += 1;
                    n_in[h] += 1;
                    return h;
                end
            return -1;
        end
        if (code == CODE_COIN0) want = 0;
        else if (code >= CODE_COIN_LO && code <= CODE_COIN_HI) want = code - CODE_COIN_LO + 1;
        else if (code >= CODE_REFILL_LO && code <= CODE_REFILL_HI)
        begin
            want = code - CODE_REFILL_LO + 1;
            refill = 1;
        end
        else return -1;
        for (int h = 0; h < NH; h++)
            if (p_enable[h] && p_coinsel[5*h +: 5] == want) pick = h;
        if (pick < 0 || lvl[pick] >= s16(p_full, pick)) return -1;
        lvl[pick] += 1;
        if (refill) n_refill[pick] += 1;
        else n_in[pick] += 1;
        if (p_lowchk[pick]) ind_low[pick] = lvl[pick] < s16(p_lowlv, pick);
        return pick;
    endfunction

    function automatic status_t apply_event(event_t w);
        status_t s = '0;
        int h = w.hopper;
        bit ok = h < NH;
        bit en = ok && p_enable[h];
        int r = -1;
        case (w.mode)
            EV_RESET:
                if (ok)
                begin
                    m_on[h] = 0; m_prev[h] = 0; o_en[h] = 0; o_flag[h] = 0;
                    ph_timer[h] = 0; ph[h] = PH_IDLE;
                end
            EV_MOTOR:
                if (en)
                begin
                    m_on[h] = w.flag_in;
                    if (w.flag_in && !m_prev[h])
                    begin
                        ph[h] = PH_SPIN;
                        ph_timer[h] = 0;
                    end
                    else if (!w.flag_in && m_prev[h])
                    begin
                        ph[h] = PH_IDLE; ph_timer[h] = 0; o_flag[h] = 0;
                    end
                    m_prev[h] = w.flag_in;
                end
            EV_OPTO_WR: if (en) o_en[h] = w.flag_in;
            EV_OPTO_RD: if (en && o_en[h]) s.opto = o_flag[h];
            EV_TICK: if (en) run_tick(h, w.tick_cycles);
            EV_COIN: r = route_coin(w.coin_code);
            EV_LOAD: if (ok) lvl[h] = w.level_value;
            default: ;
        endcase
        if (r >= 0)
        begin
            s.routed = 1;
            s.coin_h = r[3:0];
        end
        if (ok)
        begin
            s.level = lvl[h]; s.cin = n_in[h]; s.cpaid = n_paid[h];
            s.crefill = n_refill[h]; s.low = ind_low[h]; s.high = ind_high[h];
            s.phase = ph[h];
        end
        return s;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    endtask

    // driver: hold the word until accepted, advance on handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_status.push_back(apply_event({mode, hopper, flag_in, tick_cycles,
                                                       coin_code, level_value}));
            if (!(in_valid && !in_ready))
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    event_t w;
                    if (!quiet && $urandom_range(0, 15) == 0)
                    begin
                        in_gap = $urandom_range(1, 19) - 1;
                        in_valid <= 1'b0;
                    end
                    else
                    begin
                        w = pending_words.pop_front();
                        {mode, hopper, flag_in, tick_cycles, coin_code, level_value} <= w;
                        in_valid <= 1'b1;
                    end
                end
                else in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        status_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("coin_hopper_payout_controller verification failed");
            $finish;
        end
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_status.size() == 0)
                    report("unexpected word", 0, 0);
                else
                begin
                    e = expected_status.pop_front();
                    if (opto_out !== e.opto) report("opto_out", opto_out, e.opto);
                    if (coin_routed !== e.routed) report("coin_routed", coin_routed, e.routed);
                    if (coin_hopper !== e.coin_h) report("coin_hopper", coin_hopper, e.coin_h);
                    if (hopper_level_out !== e.level)
                        report("hopper_level_out", hopper_level_out, e.level);
                    if (coins_in_out !== e.cin) report("coins_in_out", coins_in_out, e.cin);
                    if (coins_paid_out !== e.cpaid)
                        report("coins_paid_out", coins_paid_out, e.cpaid);
                    if (coins_refilled_out !== e.crefill)
                        report("coins_refilled_out", coins_refilled_out, e.crefill);
                    if (low_flag !== e.low) report("low_flag", low_flag, e.low);
                    if (high_flag !== e.high) report("high_flag", high_flag, e.high);
                    if (motor_phase !== e.phase) report("motor_phase", motor_phase, e.phase);
                end
            end
            // stall the result side in random bursts
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                out_gap = $urandom_range(1, 19) - 1;
                out_ready <= 1'b0;
            end
            else out_ready <= 1'b1;
        end
    end

    function automatic event_t rand_word();
        event_t w;
        w.mode = 3'($urandom_range(0, 7));
        w.hopper = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 3));
        w.flag_in = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: w.tick_cycles = 16'($urandom_range(0, 65535));
            1: w.tick_cycles = 16'hFFFF;
            default: w.tick_cycles = 16'($urandom_range(20000, 60000));
        endcase
        case ($urandom_range(0, 3))
            0: w.coin_code = 8'($urandom_range(0, 255));
            1: w.coin_code = 8'($urandom_range(0, 12));
            2: w.coin_code = CODE_COIN_LO + 8'($urandom_range(0, 15));
            default: w.coin_code = ($urandom_range(0, 1)) ? CODE_COIN0
                                                          : CODE_REFILL_LO + 8'($urandom_range(0, 15));
        endcase
        w.level_value = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(0, 8));
        return w;
    endfunction

    function automatic event_t mk(logic [2:0] m, logic [3:0] h, logic f, logic [15:0] t,
                                  logic [7:0] c, logic [15:0] l);
        return {m, h, f, t, c, l};
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_ENABLE: p_enable = val[3:0];
            REG_COINSEL: p_coinsel = val[19:0];
            REG_FULL: p_full = val;
            REG_LOW: p_lowlv = val;
            REG_HIGH: p_highlv = val;
            REG_LOWCHK: p_lowchk = val[3:0];
            REG_HIGHCHK: p_highchk = val[3:0];
            default: p_edc = val[0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every queued word has been sent and answered
    task automatic drain();
        while (pending_words.size() > 0 || in_valid || expected_status.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic random_setting(bit extreme);
        write_reg(REG_ENABLE, extreme ? 64'hF : 64'($urandom_range(0, 15)));
        write_reg(REG_COINSEL, extreme ? 64'hFFFFF
                  : 64'({5'($urandom_range(0, 3)), 5'($urandom_range(0, 3)),
                         5'($urandom_range(0, 3)), 5'($urandom_range(0, 3))}));
        write_reg(REG_FULL, extreme ? 64'hFFFF_FFFF_FFFF_FFFF
                  : {16'($urandom_range(0, 10)), 16'($urandom_range(0, 10)),
                     16'($urandom_range(0, 10)), 16'($urandom_range(0, 10))});
        write_reg(REG_LOW, extreme ? 64'h0 : {$urandom, $urandom} & 64'h0007_0007_0007_0007);
        write_reg(REG_HIGH, extreme ? 64'hFFFF_FFFF_FFFF_FFFF
                  : {$urandom, $urandom} & 64'h000F_000F_000F_000F);
        write_reg(REG_LOWCHK, extreme ? 64'hF : 64'($urandom_range(0, 15)));
        write_reg(REG_HIGHCHK, extreme ? 64'hF : 64'($urandom_range(0, 15)));
        write_reg(REG_INMODE, 64'($urandom_range(0, 1)));
    endtask

    initial
    begin
        event_t w;
        clear_bank();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: coin map 0,1,2,1 plain mode, thresholds mid-range
        write_reg(REG_ENABLE, 64'b1011);
        write_reg(REG_COINSEL, 64'({5'd1, 5'd2, 5'd1, 5'd0}));
        write_reg(REG_FULL, {16'd5, 16'd5, 16'd5, 16'd2});
        write_reg(REG_LOW, {16'd1, 16'd1, 16'd1, 16'd1});
        write_reg(REG_HIGH, {16'd4, 16'd4, 16'd4, 16'd4});
        write_reg(REG_LOWCHK, 64'hF);
        write_reg(REG_HIGHCHK, 64'hF);
        write_reg(REG_INMODE, 64'd0);
        pending_words.push_back(mk(EV_COIN, 0, 0, 0, 8'd0, 0));
        pending_words.push_back(mk(EV_COIN, 0, 0, 0, 8'd1, 0));
        pending_words.push_back(mk(EV_COIN, 0, 0, 0, 8'd12, 0));
        pending_words.push_back(mk(EV_COIN, 0, 0, 0, 8'd13, 0));
        pending_words.push_back(mk(EV_COIN, 0, 0, 0, 8'hFF, 0));
        pending_words.push_back(mk(EV_LOAD, 0, 0, 0, 0, 16'd1));
        pending_words.push_back(mk(EV_LOAD, 2, 0, 0, 0, 16'hFFFF));
        pending_words.push_back(mk(EV_OPTO_WR, 0, 1, 0, 0, 0));
        pending_words.push_back(mk(EV_MOTOR, 0, 1, 0, 0, 0));
        pending_words.push_back(mk(EV_TICK, 0, 0, 16'hFFFF, 0, 0));
        pending_words.push_back(mk(EV_TICK, 0, 0, 16'hFFFF, 0, 0));
        pending_words.push_back(mk(EV_TICK, 0, 0, 16'd1, 0, 0));
        pending_words.push_back(mk(EV_OPTO_RD, 0, 0, 0, 0, 0));
        pending_words.push_back(mk(EV_TICK, 0, 0, 16'hFFFF, 0, 0));
        pending_words.push_back(mk(EV_TICK, 0, 0, 16'hFFFF, 0, 0));
        pending_words.push_back(mk(EV_TICK, 0, 0, 16'hFFFF, 0, 0));
        pending_words.push_back(mk(EV_MOTOR, 0, 0, 0, 0, 0));
        pending_words.push_back(mk(EV_MOTOR, 2, 1, 0, 0, 0));
        pending_words.push_back(mk(EV_OPTO_RD, 2, 0, 0, 0, 0));
        pending_words.push_back(mk(EV_RESET, 0, 0, 0, 0, 0));
        pending_words.push_back(mk(EV_LOAD, 4'hF, 0, 0, 0, 16'd7));
        pending_words.push_back(mk(3'd7, 1, 1, 0, 0, 0));
        drain();

        // pause the sender: every expected word must come back first
        write_reg(REG_INMODE, 64'd1);
        pending_words.push_back(mk(EV_COIN, 0, 0, 0, CODE_COIN0, 0));
        pending_words.push_back(mk(EV_COIN, 1, 0, 0, CODE_COIN_LO, 0));
        pending_words.push_back(mk(EV_COIN, 3, 0, 0, CODE_REFILL_LO, 0));
        pending_words.push_back(mk(EV_COIN, 3, 0, 0, CODE_REFILL_HI, 0));
        pending_words.push_back(mk(EV_COIN, 3, 0, 0, CODE_COIN_HI, 0));
        drain();

        // random phases: all event kinds, mode 7 mostly turned into ticks, mostly in-range hoppers
        for (int phz = 0; phz < 12; phz++)
        begin
            random_setting(phz == 0 || phz == 11);
            if (phz == 10) quiet = 1;
            for (int i = 0; i < 140; i++)
            begin
                w = rand_word();
                if ($urandom_range(0, 3) != 0 && w.mode == 3'd7) w.mode = EV_TICK;
                pending_words.push_back(w);
            end
            drain();
        end

        if (errors == 0)
            $display("coin_hopper_payout_controller verification clean");
        else
            $display("coin_hopper_payout_controller verification failed");
        $finish;
    end
endmodule
